// ===== rtl/core/rcw_pkg.sv =====
package rcw_pkg;

  // field and datapath widths
  localparam int MSS_W      = 13;
  localparam int WIN_W      = 16;
  localparam int FRAC_W     = 8;
  localparam int FIX_W      = WIN_W + FRAC_W;
  localparam int SQ_W       = 2 * MSS_W;
  localparam int ACKED_W    = 6;
  localparam int CMD_W      = 2;
  localparam int PHASE_W    = 2;
  localparam int DUP_W      = 3;
  localparam int DIV_STEPS  = FIX_W;
  localparam int MOD_STEPS  = WIN_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // event kinds
  localparam logic [CMD_W-1:0] CMD_ACK     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  // window phases
  localparam logic [PHASE_W-1:0] PH_SLOW_START = 2'd0;
  localparam logic [PHASE_W-1:0] PH_CONG_AVOID = 2'd1;
  localparam logic [PHASE_W-1:0] PH_FAST_RECOV = 2'd2;

  localparam logic [DUP_W-1:0] DUP_MAX        = 3'd7;
  localparam logic [DUP_W-1:0] DUP_BEFORE_FR  = 3'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_SIZE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_WINDOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_CEILING    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_FLOOR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_SPACE    = 3'd5;

  // register reset values
  localparam logic [MSS_W-1:0] RST_SEGMENT_SIZE      = 13'd512;
  localparam logic [WIN_W-1:0] RST_INITIAL_WINDOW    = 16'd512;
  localparam logic [WIN_W-1:0] RST_INITIAL_THRESHOLD = 16'd10240;
  localparam logic [WIN_W-1:0] RST_WINDOW_CEILING    = 16'd10240;
  localparam logic [WIN_W-1:0] RST_THRESHOLD_FLOOR   = 16'd1024;
  localparam logic [WIN_W-1:0] RST_SEQUENCE_SPACE    = 16'd25600;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [ACKED_W-1:0] acked_segments;
    logic [WIN_W-1:0]   window_base;
    logic [WIN_W-1:0]   next_seq;
  } in_item_t;

  typedef struct packed {
    logic [WIN_W-1:0]   window_bytes;
    logic [WIN_W-1:0]   threshold;
    logic [PHASE_W-1:0] mode;
    logic               retransmit;
    logic [WIN_W-1:0]   bytes_free;
  } out_item_t;

  typedef struct packed {
    logic [MSS_W-1:0] segment_size;
    logic [WIN_W-1:0] initial_window;
    logic [WIN_W-1:0] initial_threshold;
    logic [WIN_W-1:0] window_ceiling;
    logic [WIN_W-1:0] threshold_floor;
    logic [WIN_W-1:0] sequence_space;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_CLR_DUP,
    OP_SS_STEP,
    OP_FR_DEFLATE,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_CA_GROW,
    OP_DUP_GROW,
    OP_LOSS_THRESH,
    OP_FR_LOAD,
    OP_TO_LOAD,
    OP_RESTART,
    OP_MOD_START,
    OP_MOD_STEP,
    OP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   outst_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               dup_to_three;
  } dp_sts_t;

endpackage

// ===== rtl/core/rcw_dp.sv =====
module rcw_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  rcw_pkg::cfg_t      cfg,
  input  rcw_pkg::in_item_t  in_item,
  input  rcw_pkg::dp_cmd_t   cmd,
  output rcw_pkg::dp_sts_t   sts,
  output rcw_pkg::out_item_t out_item
);

  localparam int FIX_W   = rcw_pkg::FIX_W;
  localparam int WIN_W   = rcw_pkg::WIN_W;
  localparam int FRAC_W  = rcw_pkg::FRAC_W;
  localparam int SQ_W    = rcw_pkg::SQ_W;
  localparam int MSS_W   = rcw_pkg::MSS_W;
  localparam int PHASE_W = rcw_pkg::PHASE_W;
  localparam int DUP_W   = rcw_pkg::DUP_W;

  // window growth, saturating at the ceiling
  function automatic logic [FIX_W-1:0] grow_win(input logic [FIX_W-1:0] win,
                                                input logic [FIX_W-1:0] inc,
                                                input logic [WIN_W-1:0] ceiling_b);
    logic [FIX_W:0] sum;
    logic [FIX_W:0] lim;
    sum = {1'b0, win} + {1'b0, inc};
    lim = {1'b0, ceiling_b, {FRAC_W{1'b0}}};
    if (win[FIX_W-1:FRAC_W] >= ceiling_b) begin
      grow_win = win;
    end else if (sum >= lim) begin
      grow_win = lim[FIX_W-1:0];
    end else begin
      grow_win = sum[FIX_W-1:0];
    end
  endfunction

  // window state
  logic [FIX_W-1:0]   wf_r, wf_nxt;
  logic [WIN_W-1:0]   ssth_r, ssth_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [DUP_W-1:0]   dup_r, dup_nxt;
  logic               retx_r, retx_nxt;

  // working registers
  logic [SQ_W-1:0]    sq_r, sq_nxt;
  logic [FIX_W-1:0]   rem_r, rem_nxt;
  logic [FIX_W-1:0]   dq_r, dq_nxt;
  logic               sat_r, sat_nxt;
  logic [WIN_W-1:0]   base_sh_r, base_sh_nxt;
  logic [WIN_W-1:0]   nxt_sh_r, nxt_sh_nxt;
  logic [WIN_W-1:0]   base_rem_r, base_rem_nxt;
  logic [WIN_W-1:0]   nxt_rem_r, nxt_rem_nxt;
  logic [WIN_W-1:0]   outst_r, outst_nxt;
  rcw_pkg::out_item_t out_r, out_nxt;

  logic [SQ_W-1:0]    sq_prod;
  logic [FIX_W-1:0]   ss_inc, ss_win, ca_inc, ca_win, fr_win;
  logic [WIN_W-1:0]   half_win, loss_thr, win_int, free_bytes;
  logic [MSS_W+1:0]   mss3;
  logic [WIN_W:0]     fr_sum;
  logic [FIX_W:0]     div_cat, div_sub;
  logic               div_ge;
  logic [WIN_W:0]     modulus;
  logic [WIN_W:0]     b_cat, b_sub, n_cat, n_sub;
  logic [WIN_W:0]     o_diff, o_wrap;

  assign sq_prod  = SQ_W'(cfg.segment_size) * SQ_W'(cfg.segment_size);
  assign ss_inc   = FIX_W'({cfg.segment_size, {FRAC_W{1'b0}}});
  assign ss_win   = grow_win(wf_r, ss_inc, cfg.window_ceiling);
  assign ca_inc   = sat_r ? {FIX_W{1'b1}} : dq_r;
  assign ca_win   = grow_win(wf_r, ca_inc, cfg.window_ceiling);

  assign half_win = {1'b0, wf_r[FIX_W-1:FRAC_W+1]};
  assign loss_thr = (half_win > cfg.threshold_floor) ? half_win : cfg.threshold_floor;

  // three segments on top of the threshold, saturated
  assign mss3   = (MSS_W+2)'(cfg.segment_size) + (MSS_W+2)'({cfg.segment_size, 1'b0});
  assign fr_sum = {1'b0, ssth_r} + (WIN_W+1)'(mss3);
  assign fr_win = fr_sum[WIN_W] ? {FIX_W{1'b1}} : {fr_sum[WIN_W-1:0], {FRAC_W{1'b0}}};

  // restoring divide step, one quotient bit
  assign div_cat = {rem_r, dq_r[FIX_W-1]};
  assign div_sub = div_cat - {1'b0, wf_r};
  assign div_ge  = (div_cat >= {1'b0, wf_r});

  // sequence space of zero means the full 16-bit space
  assign modulus = (cfg.sequence_space == '0) ? {1'b1, {WIN_W{1'b0}}}
                                              : {1'b0, cfg.sequence_space};
  assign b_cat = {base_rem_r, base_sh_r[WIN_W-1]};
  assign b_sub = b_cat - modulus;
  assign n_cat = {nxt_rem_r, nxt_sh_r[WIN_W-1]};
  assign n_sub = n_cat - modulus;

  assign o_diff = {1'b0, nxt_rem_r} - {1'b0, base_rem_r};
  assign o_wrap = o_diff + modulus;

  assign win_int    = wf_r[FIX_W-1:FRAC_W];
  assign free_bytes = (win_int > outst_r) ? (win_int - outst_r) : '0;

  always_comb begin
    wf_nxt       = wf_r;
    ssth_nxt     = ssth_r;
    phase_nxt    = phase_r;
    dup_nxt      = dup_r;
    retx_nxt     = retx_r;
    sq_nxt       = sq_r;
    rem_nxt      = rem_r;
    dq_nxt       = dq_r;
    sat_nxt      = sat_r;
    base_sh_nxt  = base_sh_r;
    nxt_sh_nxt   = nxt_sh_r;
    base_rem_nxt = base_rem_r;
    nxt_rem_nxt  = nxt_rem_r;
    outst_nxt    = outst_r;
    out_nxt      = out_r;
    if (cmd.outst_load) begin
      outst_nxt = (nxt_rem_r >= base_rem_r) ? o_diff[WIN_W-1:0] : o_wrap[WIN_W-1:0];
    end
    case (cmd.op)
      rcw_pkg::OP_CAPTURE: begin
        sq_nxt      = sq_prod;
        retx_nxt    = 1'b0;
        base_sh_nxt = in_item.window_base;
        nxt_sh_nxt  = in_item.next_seq;
      end
      rcw_pkg::OP_CLR_DUP: begin
        dup_nxt = '0;
      end
      rcw_pkg::OP_SS_STEP: begin
        wf_nxt = ss_win;
        if (ss_win[FIX_W-1:FRAC_W] >= ssth_r) begin
          phase_nxt = rcw_pkg::PH_CONG_AVOID;
        end
      end
      rcw_pkg::OP_FR_DEFLATE: begin
        wf_nxt    = {ssth_r, {FRAC_W{1'b0}}};
        phase_nxt = rcw_pkg::PH_CONG_AVOID;
      end
      rcw_pkg::OP_DIV_START: begin
        rem_nxt = FIX_W'(sq_r[SQ_W-1:FRAC_W]);
        dq_nxt  = {sq_r[FRAC_W-1:0], {(FIX_W-FRAC_W){1'b0}}};
        // quotient would not fit, treat as saturated
        sat_nxt = (FIX_W'(sq_r[SQ_W-1:FRAC_W]) >= wf_r);
      end
      rcw_pkg::OP_DIV_STEP: begin
        rem_nxt = div_ge ? div_sub[FIX_W-1:0] : div_cat[FIX_W-1:0];
        dq_nxt  = {dq_r[FIX_W-2:0], div_ge};
      end
      rcw_pkg::OP_CA_GROW: begin
        wf_nxt = ca_win;
      end
      rcw_pkg::OP_DUP_GROW: begin
        if (phase_r == rcw_pkg::PH_FAST_RECOV) begin
          wf_nxt = ss_win;
        end
        if (dup_r != rcw_pkg::DUP_MAX) begin
          dup_nxt = dup_r + DUP_W'(1);
        end
      end
      rcw_pkg::OP_LOSS_THRESH: begin
        ssth_nxt = loss_thr;
      end
      rcw_pkg::OP_FR_LOAD: begin
        wf_nxt    = fr_win;
        phase_nxt = rcw_pkg::PH_FAST_RECOV;
        retx_nxt  = 1'b1;
      end
      rcw_pkg::OP_TO_LOAD: begin
        wf_nxt    = ss_inc;
        phase_nxt = rcw_pkg::PH_SLOW_START;
        retx_nxt  = 1'b1;
      end
      rcw_pkg::OP_RESTART: begin
        wf_nxt    = {cfg.initial_window, {FRAC_W{1'b0}}};
        ssth_nxt  = cfg.initial_threshold;
        phase_nxt = rcw_pkg::PH_SLOW_START;
        dup_nxt   = '0;
      end
      rcw_pkg::OP_MOD_START: begin
        base_rem_nxt = '0;
        nxt_rem_nxt  = '0;
      end
      rcw_pkg::OP_MOD_STEP: begin
        base_rem_nxt = (b_cat >= modulus) ? b_sub[WIN_W-1:0] : b_cat[WIN_W-1:0];
        nxt_rem_nxt  = (n_cat >= modulus) ? n_sub[WIN_W-1:0] : n_cat[WIN_W-1:0];
        base_sh_nxt  = {base_sh_r[WIN_W-2:0], 1'b0};
        nxt_sh_nxt   = {nxt_sh_r[WIN_W-2:0], 1'b0};
      end
      rcw_pkg::OP_PUBLISH: begin
        out_nxt.window_bytes = win_int;
        out_nxt.threshold    = ssth_r;
        out_nxt.mode         = phase_r;
        out_nxt.retransmit   = retx_r;
        out_nxt.bytes_free   = free_bytes;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wf_r    <= {rcw_pkg::RST_INITIAL_WINDOW, {FRAC_W{1'b0}}};
      ssth_r  <= rcw_pkg::RST_INITIAL_THRESHOLD;
      phase_r <= rcw_pkg::PH_SLOW_START;
      dup_r   <= '0;
      retx_r  <= 1'b0;
    end else begin
      wf_r    <= wf_nxt;
      ssth_r  <= ssth_nxt;
      phase_r <= phase_nxt;
      dup_r   <= dup_nxt;
      retx_r  <= retx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sq_r       <= sq_nxt;
    rem_r      <= rem_nxt;
    dq_r       <= dq_nxt;
    sat_r      <= sat_nxt;
    base_sh_r  <= base_sh_nxt;
    nxt_sh_r   <= nxt_sh_nxt;
    base_rem_r <= base_rem_nxt;
    nxt_rem_r  <= nxt_rem_nxt;
    outst_r    <= outst_nxt;
    out_r      <= out_nxt;
  end

  assign sts.phase        = phase_r;
  assign sts.dup_to_three = (dup_r == rcw_pkg::DUP_BEFORE_FR);
  assign out_item         = out_r;

endmodule

// ===== rtl/core/rcw_ctrl.sv =====
module rcw_ctrl #(
  parameter int MAX_ACKED_PER_EVENT = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  rcw_pkg::in_item_t in_item,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  rcw_pkg::dp_sts_t  sts,
  output rcw_pkg::dp_cmd_t  cmd
);

  localparam int CNT_W  = $clog2(MAX_ACKED_PER_EVENT + 1);
  localparam int CMP_W  = rcw_pkg::ACKED_W + 1;
  localparam int STEP_W = rcw_pkg::STEP_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACK_NEW,
    S_SEG,
    S_DIV,
    S_CA_GROW,
    S_DUP,
    S_FR_THRESH,
    S_FR_LOAD,
    S_TO_THRESH,
    S_TO_LOAD,
    S_RESTART,
    S_MOD_START,
    S_MOD,
    S_OUTST,
    S_PUBLISH
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  seg_cnt_r, seg_cnt_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  acked_cap;
  logic              out_free;

  // segment count saturated at the per-event limit
  assign acked_cap = ({1'b0, in_item.acked_segments} > CMP_W'(MAX_ACKED_PER_EVENT))
                   ? CNT_W'(MAX_ACKED_PER_EVENT) : CNT_W'(in_item.acked_segments);
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    seg_cnt_nxt    = seg_cnt_r;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r && out_stall;
    cmd.op         = rcw_pkg::OP_NONE;
    cmd.outst_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = rcw_pkg::OP_CAPTURE;
          if (in_item.command == rcw_pkg::CMD_ACK) begin
            if (in_item.acked_segments == '0) begin
              state_nxt = S_DUP;
            end else begin
              seg_cnt_nxt = acked_cap;
              state_nxt   = S_ACK_NEW;
            end
          end else if (in_item.command == rcw_pkg::CMD_TIMEOUT) begin
            state_nxt = S_TO_THRESH;
          end else if (in_item.command == rcw_pkg::CMD_RESTART) begin
            state_nxt = S_RESTART;
          end else begin
            state_nxt = S_MOD_START;
          end
        end
      end
      S_ACK_NEW: begin
        cmd.op    = rcw_pkg::OP_CLR_DUP;
        state_nxt = S_SEG;
      end
      S_SEG: begin
        if (seg_cnt_r == '0) begin
          state_nxt = S_MOD_START;
        end else if (sts.phase == rcw_pkg::PH_SLOW_START) begin
          cmd.op      = rcw_pkg::OP_SS_STEP;
          seg_cnt_nxt = seg_cnt_r - CNT_W'(1);
        end else if (sts.phase == rcw_pkg::PH_CONG_AVOID) begin
          cmd.op    = rcw_pkg::OP_DIV_START;
          step_nxt  = STEP_W'(rcw_pkg::DIV_STEPS - 1);
          state_nxt = S_DIV;
        end else begin
          cmd.op      = rcw_pkg::OP_FR_DEFLATE;
          seg_cnt_nxt = seg_cnt_r - CNT_W'(1);
        end
      end
      S_DIV: begin
        cmd.op = rcw_pkg::OP_DIV_STEP;
        if (step_r == '0) begin
          state_nxt = S_CA_GROW;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      S_CA_GROW: begin
        cmd.op      = rcw_pkg::OP_CA_GROW;
        seg_cnt_nxt = seg_cnt_r - CNT_W'(1);
        state_nxt   = S_SEG;
      end
      S_DUP: begin
        cmd.op    = rcw_pkg::OP_DUP_GROW;
        state_nxt = sts.dup_to_three ? S_FR_THRESH : S_MOD_START;
      end
      S_FR_THRESH: begin
        cmd.op    = rcw_pkg::OP_LOSS_THRESH;
        state_nxt = S_FR_LOAD;
      end
      S_FR_LOAD: begin
        cmd.op    = rcw_pkg::OP_FR_LOAD;
        state_nxt = S_MOD_START;
      end
      S_TO_THRESH: begin
        cmd.op    = rcw_pkg::OP_LOSS_THRESH;
        state_nxt = S_TO_LOAD;
      end
      S_TO_LOAD: begin
        cmd.op    = rcw_pkg::OP_TO_LOAD;
        state_nxt = S_MOD_START;
      end
      S_RESTART: begin
        cmd.op    = rcw_pkg::OP_RESTART;
        state_nxt = S_MOD_START;
      end
      S_MOD_START: begin
        cmd.op    = rcw_pkg::OP_MOD_START;
        step_nxt  = STEP_W'(rcw_pkg::MOD_STEPS - 1);
        state_nxt = S_MOD;
      end
      S_MOD: begin
        cmd.op = rcw_pkg::OP_MOD_STEP;
        if (step_r == '0) begin
          state_nxt = S_OUTST;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      S_OUTST: begin
        cmd.outst_load = 1'b1;
        state_nxt      = S_PUBLISH;
      end
      S_PUBLISH: begin
        if (out_free) begin
          cmd.op        = rcw_pkg::OP_PUBLISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seg_cnt_r   <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seg_cnt_r   <= seg_cnt_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/reno_congestion_window_top.sv =====
// channel  | direction | handshake            | payload
// in_      | input     | in_valid / in_stall   | rcw_pkg::in_item_t (event)
// out_     | output    | out_valid / out_stall | rcw_pkg::out_item_t (window report)
// cfg_     | input     | cfg_wr_en             | cfg_index, cfg_wdata (no read-back)
//
// work done for each item, from the accept to the result register:
//   new ack: one window step per segment in slow start or fast recovery,
//            or per segment in congestion avoidance a 24-step shift-subtract divide
//   duplicate ack, with threshold and fast-recovery loads on the third; timeout; restart; other code
//   every item passes through the 16-step bit-serial sequence-number reduction
// one item at a time: in_stall is high from the accept until the result is registered
// a finished result waits in the output register; the next item is accepted meanwhile
// reset is synchronous, active low, and loads the register defaults and the initial window

module reno_congestion_window_top #(
  parameter int MAX_ACKED_PER_EVENT = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rcw_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rcw_pkg::out_item_t                  out_item,
  input  logic                                cfg_wr_en,
  input  logic [rcw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rcw_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  rcw_pkg::cfg_t    cfg_r, cfg_nxt;
  rcw_pkg::dp_cmd_t dp_cmd;
  rcw_pkg::dp_sts_t dp_sts;

  // configuration register file, write only
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        rcw_pkg::REG_SEGMENT_SIZE:      cfg_nxt.segment_size =
                                          cfg_wdata[rcw_pkg::MSS_W-1:0];
        rcw_pkg::REG_INITIAL_WINDOW:    cfg_nxt.initial_window    = cfg_wdata;
        rcw_pkg::REG_INITIAL_THRESHOLD: cfg_nxt.initial_threshold = cfg_wdata;
        rcw_pkg::REG_WINDOW_CEILING:    cfg_nxt.window_ceiling    = cfg_wdata;
        rcw_pkg::REG_THRESHOLD_FLOOR:   cfg_nxt.threshold_floor   = cfg_wdata;
        rcw_pkg::REG_SEQUENCE_SPACE:    cfg_nxt.sequence_space    = cfg_wdata;
        // unmapped indexes are dropped
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.segment_size      <= rcw_pkg::RST_SEGMENT_SIZE;
      cfg_r.initial_window    <= rcw_pkg::RST_INITIAL_WINDOW;
      cfg_r.initial_threshold <= rcw_pkg::RST_INITIAL_THRESHOLD;
      cfg_r.window_ceiling    <= rcw_pkg::RST_WINDOW_CEILING;
      cfg_r.threshold_floor   <= rcw_pkg::RST_THRESHOLD_FLOOR;
      cfg_r.sequence_space    <= rcw_pkg::RST_SEQUENCE_SPACE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // sequencer: per-segment loop, divider and reduction step counts, output handshake
  rcw_ctrl #(
    .MAX_ACKED_PER_EVENT (MAX_ACKED_PER_EVENT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  // window state, divider, modulo reduction and result register
  rcw_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_item  (in_item),
    .cmd      (dp_cmd),
    .sts      (dp_sts),
    .out_item (out_item)
  );

endmodule

// ===== rtl/core/rcw_checker.sv =====
module rcw_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input rcw_pkg::out_item_t out_item
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_item))
    else $error("result changed while stalled");

  // free space never exceeds the window
  a_free_le_win: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.bytes_free <= out_item.window_bytes)
    else $error("free bytes exceed window");

  // entering fast recovery sets the window to at least the new threshold
  a_fr_inflate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.retransmit && (out_item.mode == rcw_pkg::PH_FAST_RECOV)
    |-> out_item.window_bytes >= out_item.threshold)
    else $error("fast recovery window below threshold");

  // one item at a time: an accept is followed by stall
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

endmodule

bind reno_congestion_window_top rcw_checker u_rcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
